[hdl/lewtb_pkg.sv]
// ----------------------------------------------------------------------------
// lewtb_pkg
// Shared types and constants of the loop-erased walk tree builder.
// ----------------------------------------------------------------------------
`default_nettype none

package lewtb_pkg;

  // graph size
  localparam int unsigned VERTICES   = 64;
  localparam int unsigned EDGE_SLOTS = 512;
  localparam int unsigned V_W        = $clog2(VERTICES);
  localparam int unsigned SLOT_W     = $clog2(EDGE_SLOTS);
  localparam int unsigned OFF_DEPTH  = VERTICES + 1;
  localparam int unsigned OFF_AW     = $clog2(OFF_DEPTH);
  localparam int unsigned LEN_W      = V_W + 1;

  // opcodes
  localparam logic [2:0] OP_LOAD_OFFSET   = 3'd0;
  localparam logic [2:0] OP_LOAD_NEIGHBOR = 3'd1;
  localparam logic [2:0] OP_SET_FLAG      = 3'd2;
  localparam logic [2:0] OP_START         = 3'd3;
  localparam logic [2:0] OP_STEP          = 3'd4;

  // result status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_ERASED   = 3'd2;
  localparam logic [2:0] ST_EDGE     = 3'd3;
  localparam logic [2:0] ST_GAVE_UP  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  localparam logic [19:0] MAX_STEPS_RESET = 20'd65536;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  vertex;
    logic [8:0]  slot;
    logic [9:0]  word;
    logic        flag;
    logic [31:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] child;
    logic [5:0] parent;
    logic [6:0] path_length;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_MUL,
    S_NBRD,
    S_NB,
    S_SOV,
    S_PS,
    S_RES,
    S_GIVEUP,
    S_EREAD,
    S_EEMIT
  } state_e;

endpackage

`default_nettype wire

[hdl/lewtb_ram.sv]
// ----------------------------------------------------------------------------
// lewtb_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lewtb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 6,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/loop_erased_walk_tree_builder.sv]
// ----------------------------------------------------------------------------
// loop_erased_walk_tree_builder
// Loop-erased random walk (Wilson) over a compressed graph in on-chip RAMs.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | lewtb_pkg::in_item_t
//  out     | output    | out_valid_o / out_stall_i | lewtb_pkg::out_item_t
//  cfg     | input     | cfg_we_i                  | max_steps (20 bits)
//
// A proposing step runs up to the chain offset -> offset -> multiply -> neighbor
// -> slot -> path RAM reads; a zero-degree step stops after the offsets, a
// step past the budget gives up at once, and a trailing give-up adds a
// second result. A tree hit emits one edge per path vertex, read back first.
// Reset clears tree flags, visit marks and walk control; RAMs need no clear.
// A stalled output holds the block in its emit state; no input is taken
// until the current transaction's results are all issued.
// ----------------------------------------------------------------------------
`default_nettype none

module loop_erased_walk_tree_builder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [19:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lewtb_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lewtb_pkg::out_item_t      out_data_o
);

  import lewtb_pkg::*;

  state_e              state_q, state_d;
  logic [19:0]         max_steps_q;
  logic [19:0]         step_cnt_q, step_cnt_d;
  logic                walking_q, walking_d;
  logic [LEN_W-1:0]    path_len_q, path_len_d;
  logic [V_W-1:0]      endpoint_q, endpoint_d;
  logic [VERTICES-1:0] in_tree_q, in_tree_d;
  logic [VERTICES-1:0] seen_q, seen_d;
  in_item_t            item_q, item_d;
  logic [9:0]          lo_q, lo_d;
  logic [9:0]          deg_q, deg_d;
  logic [9:0]          pick_q, pick_d;
  logic [V_W-1:0]      nb_q, nb_d;
  logic [V_W-1:0]      parent_q, parent_d;
  logic [V_W-1:0]      idx_q, idx_d;
  out_item_t           res_q, res_d;
  logic                gu_pend_q, gu_pend_d;
  logic                out_valid_q;
  out_item_t           out_data_q;

  logic                push;
  out_item_t           push_item;
  logic                out_free;
  logic [41:0]         prod;
  logic                accept;

  // memory ports
  logic                off_we, off_re;
  logic [OFF_AW-1:0]   off_waddr, off_raddr;
  logic [9:0]          off_rdata;
  logic                nbr_we, nbr_re;
  logic [SLOT_W-1:0]   nbr_waddr, nbr_raddr;
  logic [V_W-1:0]      nbr_rdata;
  logic                sov_we, sov_re;
  logic [V_W-1:0]      sov_waddr, sov_raddr, sov_wdata, sov_rdata;
  logic                ps_we, ps_re;
  logic [V_W-1:0]      ps_waddr, ps_raddr, ps_wdata, ps_rdata;

  lewtb_ram #(.DEPTH(OFF_DEPTH), .WIDTH(10)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(off_waddr), .wdata_i(item_q.word),
    .re_i(off_re), .raddr_i(off_raddr), .rdata_o(off_rdata)
  );

  lewtb_ram #(.DEPTH(EDGE_SLOTS), .WIDTH(V_W)) u_nbr_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_waddr), .wdata_i(item_q.word[V_W-1:0]),
    .re_i(nbr_re), .raddr_i(nbr_raddr), .rdata_o(nbr_rdata)
  );

  lewtb_ram #(.DEPTH(VERTICES), .WIDTH(V_W)) u_sov_ram (
    .clk_i, .we_i(sov_we), .waddr_i(sov_waddr), .wdata_i(sov_wdata),
    .re_i(sov_re), .raddr_i(sov_raddr), .rdata_o(sov_rdata)
  );

  lewtb_ram #(.DEPTH(VERTICES), .WIDTH(V_W)) u_ps_ram (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(ps_wdata),
    .re_i(ps_re), .raddr_i(ps_raddr), .rdata_o(ps_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign prod       = item_q.random_word * deg_q;

  assign off_waddr = item_q.vertex[OFF_AW-1:0];
  assign nbr_waddr = item_q.slot[SLOT_W-1:0];
  assign nbr_raddr = SLOT_W'({1'b0, lo_q} + {1'b0, pick_q});

  // next state, memory control and results
  always_comb begin
    state_d    = state_q;
    step_cnt_d = step_cnt_q;
    walking_d  = walking_q;
    path_len_d = path_len_q;
    endpoint_d = endpoint_q;
    in_tree_d  = in_tree_q;
    seen_d     = seen_q;
    item_d     = item_q;
    lo_d       = lo_q;
    deg_d      = deg_q;
    pick_d     = pick_q;
    nb_d       = nb_q;
    parent_d   = parent_q;
    idx_d      = idx_q;
    res_d      = res_q;
    gu_pend_d  = gu_pend_q;
    push       = 1'b0;
    push_item  = res_q;
    off_we     = 1'b0;
    off_re     = 1'b0;
    off_raddr  = OFF_AW'(endpoint_q);
    nbr_we     = 1'b0;
    nbr_re     = 1'b0;
    sov_we     = 1'b0;
    sov_re     = 1'b0;
    sov_waddr  = nb_q;
    sov_wdata  = path_len_q[V_W-1:0];
    sov_raddr  = nb_q;
    ps_we      = 1'b0;
    ps_re      = 1'b0;
    ps_waddr   = path_len_q[V_W-1:0];
    ps_wdata   = nb_q;
    ps_raddr   = sov_rdata;

    unique case (state_q)
      // take one transaction
      S_IDLE: begin
        if (accept) begin
          item_d    = in_data_i;
          gu_pend_d = 1'b0;
          state_d   = S_RES;
          res_d     = '{status: ST_IGNORED, child: '0, parent: '0,
                        path_length: path_len_q, last: 1'b1};
          if (in_data_i.opcode == OP_STEP && walking_q) begin
            if (step_cnt_q >= max_steps_q) begin
              walking_d         = 1'b0;
              path_len_d        = '0;
              res_d.status      = ST_GAVE_UP;
              res_d.child       = endpoint_q;
              res_d.path_length = '0;
            end else begin
              step_cnt_d = step_cnt_q + 20'd1;
              off_re     = 1'b1;
              state_d    = S_LO;
            end
          end
        end
      end

      // step: low offset read back, the high offset is read now
      S_LO: begin
        lo_d      = off_rdata;
        off_re    = 1'b1;
        off_raddr = OFF_AW'({1'b0, endpoint_q} + {{V_W{1'b0}}, 1'b1});
        state_d   = S_HI;
      end

      S_HI: begin
        gu_pend_d = (step_cnt_q >= max_steps_q);
        if (off_rdata > lo_q) begin
          deg_d   = off_rdata - lo_q;
          state_d = S_MUL;
        end else begin
          res_d   = '{status: ST_IGNORED, child: '0, parent: '0,
                      path_length: path_len_q, last: !gu_pend_d};
          state_d = S_RES;
        end
      end

      S_MUL: begin
        pick_d  = prod[41:32];
        state_d = S_NBRD;
      end

      S_NBRD: begin
        nbr_re  = 1'b1;
        state_d = S_NB;
      end

      // neighbor known: hit, candidate on path, or new vertex
      S_NB: begin
        nb_d = nbr_rdata;
        if (in_tree_q[nbr_rdata]) begin
          parent_d = nbr_rdata;
          idx_d    = V_W'(path_len_q - LEN_W'(1));
          state_d  = S_EREAD;
        end else if (seen_q[nbr_rdata]) begin
          sov_re    = 1'b1;
          sov_raddr = nbr_rdata;
          state_d   = S_SOV;
        end else begin
          sov_waddr = nbr_rdata;
          ps_wdata  = nbr_rdata;
          if (path_len_q >= LEN_W'(VERTICES)) begin
            res_d = '{status: ST_IGNORED, child: '0, parent: '0,
                      path_length: path_len_q, last: !gu_pend_q};
          end else begin
            ps_we      = 1'b1;
            sov_we     = 1'b1;
            seen_d[nbr_rdata] = 1'b1;
            path_len_d = path_len_q + LEN_W'(1);
            endpoint_d = nbr_rdata;
            res_d = '{status: ST_APPENDED, child: nbr_rdata, parent: '0,
                      path_length: path_len_d, last: !gu_pend_q};
          end
          state_d = S_RES;
        end
      end

      S_SOV: begin
        if ({1'b0, sov_rdata} < path_len_q) begin
          ps_re   = 1'b1;
          state_d = S_PS;
        end else if (path_len_q >= LEN_W'(VERTICES)) begin
          res_d   = '{status: ST_IGNORED, child: '0, parent: '0,
                      path_length: path_len_q, last: !gu_pend_q};
          state_d = S_RES;
        end else begin
          ps_we      = 1'b1;
          sov_we     = 1'b1;
          path_len_d = path_len_q + LEN_W'(1);
          endpoint_d = nb_q;
          res_d = '{status: ST_APPENDED, child: nb_q, parent: '0,
                    path_length: path_len_d, last: !gu_pend_q};
          state_d = S_RES;
        end
      end

      // path slot read back: erase the loop, append, or ignore when the path is full
      S_PS: begin
        if (ps_rdata == nb_q) begin
          path_len_d = {1'b0, sov_rdata} + LEN_W'(1);
          endpoint_d = nb_q;
          res_d = '{status: ST_ERASED, child: nb_q, parent: '0,
                    path_length: path_len_d, last: !gu_pend_q};
        end else if (path_len_q >= LEN_W'(VERTICES)) begin
          res_d = '{status: ST_IGNORED, child: '0, parent: '0,
                    path_length: path_len_q, last: !gu_pend_q};
        end else begin
          ps_we      = 1'b1;
          sov_we     = 1'b1;
          path_len_d = path_len_q + LEN_W'(1);
          endpoint_d = nb_q;
          res_d = '{status: ST_APPENDED, child: nb_q, parent: '0,
                    path_length: path_len_d, last: !gu_pend_q};
        end
        state_d = S_RES;
      end

      // one result; loads, flag writes and start commit here, a pending give-up follows
      S_RES: begin
        if (out_free) begin
          push      = 1'b1;
          push_item = res_q;
          state_d   = gu_pend_q ? S_GIVEUP : S_IDLE;
          if (item_q.opcode == OP_LOAD_OFFSET
              && item_q.vertex <= 7'(VERTICES)) begin
            off_we = 1'b1;
            push_item.status = ST_DONE;
          end else if (item_q.opcode == OP_LOAD_NEIGHBOR
                       && {1'b0, item_q.slot} < 10'(EDGE_SLOTS)) begin
            nbr_we = 1'b1;
            push_item.status = ST_DONE;
          end else if (item_q.opcode == OP_SET_FLAG
                       && item_q.vertex < 7'(VERTICES)) begin
            in_tree_d[item_q.vertex[V_W-1:0]] = item_q.flag;
            push_item.status = ST_DONE;
          end else if (item_q.opcode == OP_START
                       && item_q.vertex < 7'(VERTICES)) begin
            ps_we     = 1'b1;
            ps_waddr  = '0;
            ps_wdata  = item_q.vertex[V_W-1:0];
            sov_we    = 1'b1;
            sov_waddr = item_q.vertex[V_W-1:0];
            sov_wdata = '0;
            seen_d    = '0;
            seen_d[item_q.vertex[V_W-1:0]] = 1'b1;
            path_len_d = LEN_W'(1);
            endpoint_d = item_q.vertex[V_W-1:0];
            step_cnt_d = '0;
            walking_d  = 1'b1;
            push_item  = '{status: ST_DONE, child: item_q.vertex[V_W-1:0],
                           parent: '0, path_length: LEN_W'(1), last: 1'b1};
          end
        end
      end

      S_GIVEUP: begin
        if (out_free) begin
          push       = 1'b1;
          push_item  = '{status: ST_GAVE_UP, child: endpoint_q, parent: '0,
                         path_length: '0, last: 1'b1};
          walking_d  = 1'b0;
          path_len_d = '0;
          gu_pend_d  = 1'b0;
          state_d    = S_IDLE;
        end
      end

      // tree hit: walk the path back from the endpoint
      S_EREAD: begin
        ps_re    = 1'b1;
        ps_raddr = idx_q;
        state_d  = S_EEMIT;
      end

      S_EEMIT: begin
        if (out_free) begin
          push      = 1'b1;
          push_item = '{status: ST_EDGE, child: ps_rdata, parent: parent_q,
                        path_length: '0, last: (idx_q == '0)};
          in_tree_d[ps_rdata] = 1'b1;
          parent_d  = ps_rdata;
          if (idx_q == '0) begin
            walking_d  = 1'b0;
            path_len_d = '0;
            gu_pend_d  = 1'b0;
            state_d    = S_IDLE;
          end else begin
            idx_d   = idx_q - V_W'(1);
            state_d = S_EREAD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_steps_q <= MAX_STEPS_RESET;
      step_cnt_q  <= '0;
      walking_q   <= 1'b0;
      path_len_q  <= '0;
      endpoint_q  <= '0;
      in_tree_q   <= '0;
      seen_q      <= '0;
      gu_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;
      walking_q  <= walking_d;
      path_len_q <= path_len_d;
      endpoint_q <= endpoint_d;
      in_tree_q  <= in_tree_d;
      seen_q     <= seen_d;
      gu_pend_q  <= gu_pend_d;
      if (cfg_we_i) begin
        max_steps_q <= cfg_wdata_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    lo_q     <= lo_d;
    deg_q    <= deg_d;
    pick_q   <= pick_d;
    nb_q     <= nb_d;
    parent_q <= parent_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
    if (push) begin
      out_data_q <= push_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
